### rtl/bmhq_pkg.sv
// Shared types and codes for the binary min-heap priority queue.
package bmhq_pkg;

   // Width of a stored key
   localparam int unsigned KEY_W = 32;
   // Width of the entry count and of the capacity register
   localparam int unsigned CNT_W = 7;
   // Width of a heap position; it must hold twice the largest count
   localparam int unsigned POS_W = 8;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [POS_W-1:0]        pos_type;

   // Operation codes on req_mode
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Capacity register value after reset
   localparam cnt_type CAP_RESET = 7'd64;

endpackage

### rtl/bmhq_heap_ram.sv
// Heap key storage: one write port, two read ports with registered read data.
module bmhq_heap_ram #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  bmhq_pkg::key_type               wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr_b,
   output bmhq_pkg::key_type               rd_data_a,
   output bmhq_pkg::key_type               rd_data_b
);
   import bmhq_pkg::*;

   key_type mem_ff [DEPTH];
   key_type rd_a_ff;
   key_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, read data registered
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/binary_min_heap_queue_core.sv
// Binary min-heap priority queue of signed 32-bit keys. Each request transaction is an insert
// (req_mode 0) or a remove-minimum (req_mode 1) and yields one response transaction with the
// removed key, a status, the entry count after the operation and an empty flag. Keys live in
// a synchronous RAM with one write and two read ports; the heap walk visits each level with a
// read, then a compare and write back. A refused or empty operation goes straight to the
// final state. One transaction is in flight at a time; a finished response sits in its output
// register so the next request can be taken while it waits, and while that register is
// stalled the next result holds in the final state with the request side stalled. Inserts of
// zero are refused; inserts are refused once the count reaches the smaller of csr_wr_data's
// last written capacity (reset 64) and HEAP_DEPTH (at most 127). The RAM needs no clearing
// after reset.
module binary_min_heap_queue_core #(
   parameter int unsigned HEAP_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_wr_en,
   input  bmhq_pkg::cnt_type    csr_wr_data,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  bmhq_pkg::key_type    req_value,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bmhq_pkg::key_type    rsp_min_value,
   output logic [1:0]           rsp_status,
   output bmhq_pkg::cnt_type    rsp_entry_total,
   output logic                 rsp_queue_empty
);
   import bmhq_pkg::*;

   localparam int unsigned ADDR_W    = $clog2(HEAP_DEPTH);
   localparam cnt_type     DEPTH_LIM = CNT_W'((HEAP_DEPTH > 127) ? 127 : HEAP_DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP_RD   = 3'd1;
   localparam logic [2:0] S_UP_CMP  = 3'd2;
   localparam logic [2:0] S_DN_LOAD = 3'd3;
   localparam logic [2:0] S_DN_RD   = 3'd4;
   localparam logic [2:0] S_DN_CMP  = 3'd5;
   localparam logic [2:0] S_FIN     = 3'd6;

   logic [2:0] state_ff,  state_in;
   cnt_type    count_ff,  count_in;
   cnt_type    cap_ff,    cap_in;
   cnt_type    last_ff,   last_in;     // heap size during a sift-down
   pos_type    pos_ff,    pos_in;      // current hole position
   pos_type    child_ff,  child_in;    // left child position being compared
   key_type    key_ff,    key_in;      // key being sifted
   key_type    min_ff,    min_in;
   logic [1:0] status_ff, status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   key_type    rsp_min_ff,   rsp_min_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   cnt_type    rsp_total_ff, rsp_total_in;

   // RAM ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   key_type           wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   key_type           rd_data_a;
   key_type           rd_data_b;

   logic    req_fire;
   logic    at_limit;
   pos_type left_pos;
   pos_type parent_pos;
   logic    has_right;
   logic    take_right;
   key_type child_key;
   pos_type child_pos;

   bmhq_heap_ram #(
      .DEPTH (HEAP_DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign at_limit  = (count_ff >= cap_ff) || (count_ff >= DEPTH_LIM);

   // heap navigation
   assign left_pos   = {pos_ff[POS_W-2:0], 1'b0};
   assign parent_pos = {1'b0, pos_ff[POS_W-1:1]};
   assign has_right  = (child_ff < POS_W'(last_ff));
   assign take_right = has_right && (rd_data_a > rd_data_b);
   assign child_key  = take_right ? rd_data_b : rd_data_a;
   assign child_pos  = take_right ? (child_ff + POS_W'(1)) : child_ff;

   // sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      last_in       = last_ff;
      pos_in        = pos_ff;
      child_in      = child_ff;
      key_in        = key_ff;
      min_in        = min_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_min_in    = rsp_min_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(pos_ff - POS_W'(1));
      wr_data       = key_ff;
      rd_addr_a     = ADDR_W'(pos_ff - POS_W'(1));
      rd_addr_b     = ADDR_W'(pos_ff - POS_W'(1));

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               min_in    = '0;
               status_in = ST_DONE;
               key_in    = req_value;
               if (req_mode == MODE_INSERT) begin
                  if (req_value == '0) begin
                     status_in = ST_ZERO;
                     state_in  = S_FIN;
                  end else if (at_limit) begin
                     status_in = ST_FULL;
                     state_in  = S_FIN;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = POS_W'(count_ff) + POS_W'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     // fetch the root and the last entry together
                     rd_addr_a = '0;
                     rd_addr_b = ADDR_W'(count_ff - CNT_W'(1));
                     count_in  = count_ff - CNT_W'(1);
                     last_in   = count_ff - CNT_W'(1);
                     state_in  = S_DN_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == POS_W'(1)) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               rd_addr_a = ADDR_W'(parent_pos - POS_W'(1));
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data_a > key_ff) begin
               // parent moves down into the hole
               wr_data  = rd_data_a;
               pos_in   = parent_pos;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DN_LOAD: begin
            min_in   = rd_data_a;
            key_in   = rd_data_b;
            pos_in   = POS_W'(1);
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (left_pos > POS_W'(last_ff)) begin
               wr_en    = 1'b1;
               state_in = S_FIN;
            end else begin
               child_in  = left_pos;
               rd_addr_a = ADDR_W'(left_pos - POS_W'(1));
               rd_addr_b = (left_pos < POS_W'(last_ff)) ? ADDR_W'(left_pos)
                                                        : ADDR_W'(left_pos - POS_W'(1));
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff > child_key) begin
               // smaller child moves up into the hole
               wr_data  = child_key;
               pos_in   = child_pos;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_min_in    = min_ff;
               rsp_status_in = status_ff;
               rsp_total_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      pos_ff        <= pos_in;
      child_ff      <= child_in;
      key_ff        <= key_in;
      min_ff        <= min_in;
      status_ff     <= status_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_queue_empty = (rsp_total_ff == '0);

   // count never passes what the storage can hold
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_LIM)
      else $error("entry count beyond storage");

   // a refused or empty operation reports a zero key
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_min_value == '0))
      else $error("refused operation with nonzero key");

   // an accepted request always leaves work pending, so a new one waits for the last response
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("accepted request left no work pending");

   // a sift-up for an insert never runs on an empty queue or at position zero
   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_RD) |-> (count_ff != '0 && pos_ff != '0))
      else $error("sift-up with empty heap");

endmodule

### tb/tb_binary_min_heap_queue_core.sv
// Self-checking testbench for the binary min-heap priority queue core.
`timescale 1ns / 100ps

module tb_binary_min_heap_queue_core;
   import bmhq_pkg::*;

   localparam int unsigned HEAP_DEPTH = 64;

   // One response transaction as the queue should produce it
   typedef struct {
      key_type      min_value;
      logic [1:0]   status;
      cnt_type      entry_total;
      logic         queue_empty;
   } queue_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   cnt_type     csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = MODE_INSERT;
   key_type     req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   key_type     rsp_min_value;
   logic [1:0]  rsp_status;
   cnt_type     rsp_entry_total;
   logic        rsp_queue_empty;

   // Shadow heap, one-based like the block's positions
   key_type          shadow_keys [1:HEAP_DEPTH];
   int unsigned      shadow_count = 0;
   cnt_type          shadow_capacity = CAP_RESET;
   queue_result_type pending_results [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int stall_hold_left = 0;
   int error_count = 0;

   binary_min_heap_queue_core #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_min_value   (rsp_min_value),
      .rsp_status      (rsp_status),
      .rsp_entry_total (rsp_entry_total),
      .rsp_queue_empty (rsp_queue_empty)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Run the heap operation on the shadow copy and queue the response it implies
   function automatic void apply_heap_op(input logic op_mode, input key_type op_value);
      queue_result_type r;
      int unsigned      pos;
      int unsigned      child;
      int unsigned      cap;
      key_type          tmp;
      r.min_value = '0;
      r.status = ST_DONE;
      cap = (shadow_capacity > HEAP_DEPTH) ? HEAP_DEPTH : shadow_capacity;
      if (op_mode == MODE_INSERT) begin
         if (op_value == 0) begin
            r.status = ST_ZERO;
         end else if (shadow_count >= cap) begin
            r.status = ST_FULL;
         end else begin
            shadow_count++;
            pos = shadow_count;
            shadow_keys[pos] = op_value;
            // sift up: move only while strictly out of order
            while (pos > 1 && shadow_keys[pos / 2] > shadow_keys[pos]) begin
               tmp = shadow_keys[pos / 2];
               shadow_keys[pos / 2] = shadow_keys[pos];
               shadow_keys[pos] = tmp;
               pos = pos / 2;
            end
         end
      end else if (shadow_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.min_value = shadow_keys[1];
         shadow_keys[1] = shadow_keys[shadow_count];
         shadow_count--;
         pos = 1;
         // sift down; equal children resolve to the left one
         while (2 * pos <= shadow_count) begin
            child = 2 * pos;
            if (child < shadow_count && shadow_keys[child] > shadow_keys[child + 1])
               child++;
            if (!(shadow_keys[pos] > shadow_keys[child]))
               break;
            tmp = shadow_keys[pos];
            shadow_keys[pos] = shadow_keys[child];
            shadow_keys[child] = tmp;
            pos = child;
         end
      end
      r.entry_total = cnt_type'(shadow_count);
      r.queue_empty = (shadow_count == 0);
      pending_results.push_back(r);
   endfunction

   // Keys biased toward ties, extremes and the odd zero
   function automatic key_type random_key();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return key_type'($urandom);
      else if (pick < 8)
         return key_type'($signed($urandom_range(16)) - 8);
      else
         case ($urandom_range(3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd1;
            default: return -32'sd1;
         endcase
   endfunction

   // Offer one request transaction, with random idle cycles ahead of it
   task automatic send_op(input logic op_mode, input key_type op_value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op_mode;
      req_value <= op_value;
      do @(posedge clock); while (req_stall);
      apply_heap_op(op_mode, op_value);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_queue();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Capacity is only written with the block idle
   task automatic write_capacity(input cnt_type cap);
      drain_queue();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_capacity = cap;
   endtask

   // Response stall: random per cycle, or a long hold-off when requested
   always @(posedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      queue_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no pending request: min_value %0d status %0d",
                   rsp_min_value, rsp_status);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_min_value !== exp_r.min_value) begin
               $error("min_value: expected %0d, actual %0d", exp_r.min_value, rsp_min_value);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_total !== exp_r.entry_total) begin
               $error("entry_total: expected %0d, actual %0d",
                      exp_r.entry_total, rsp_entry_total);
               error_count++;
            end
            if (rsp_queue_empty !== exp_r.queue_empty) begin
               $error("queue_empty: expected %0d, actual %0d",
                      exp_r.queue_empty, rsp_queue_empty);
               error_count++;
            end
         end
      end
   end

   // Extreme keys, zero, ties and removes on an empty queue
   task automatic test_corner_keys();
      send_op(MODE_REMOVE, 32'sh1234_5678);
      send_op(MODE_INSERT, 32'sd0);
      send_op(MODE_INSERT, 32'sh7FFF_FFFF);
      send_op(MODE_INSERT, 32'sh8000_0000);
      send_op(MODE_INSERT, -32'sd1);
      send_op(MODE_INSERT, 32'sd1);
      send_op(MODE_INSERT, 32'sd5);
      send_op(MODE_INSERT, 32'sd5);
      send_op(MODE_INSERT, -32'sd1);
      repeat (8) send_op(MODE_REMOVE, 32'shFFFF_FFFF);
      send_op(MODE_REMOVE, '0);
   endtask

   // Capacity zero, one, and lowered below the current count
   task automatic test_capacity();
      write_capacity(7'd0);
      send_op(MODE_INSERT, 32'sd3);
      send_op(MODE_REMOVE, '0);
      write_capacity(7'd1);
      send_op(MODE_INSERT, 32'sd4);
      send_op(MODE_INSERT, 32'sd9);
      write_capacity(7'd64);
      send_op(MODE_INSERT, 32'sd6);
      send_op(MODE_INSERT, 32'sd2);
      write_capacity(7'd2);
      send_op(MODE_INSERT, 32'sd8);
      send_op(MODE_REMOVE, '0);
      send_op(MODE_INSERT, 32'sd8);
      send_op(MODE_REMOVE, '0);
      send_op(MODE_INSERT, 32'sd8);
      send_op(MODE_REMOVE, '0);
      send_op(MODE_REMOVE, '0);
   endtask

   // Fill past depth with the limit above depth, then empty it; starts under a long hold-off
   task automatic test_fill_and_drain();
      key_type k;
      write_capacity(7'd127);
      send_idle_pct = 0;
      rsp_stall_pct = 24;
      stall_hold_left = 400;
      for (int i = 0; i < HEAP_DEPTH + 2; i++) begin
         k = random_key();
         if (k == 0)
            k = 32'sd77;
         send_op(MODE_INSERT, k);
      end
      for (int i = 0; i < HEAP_DEPTH + 2; i++)
         send_op(MODE_REMOVE, key_type'($urandom));
   endtask

   // Random traffic alternating growth and shrink, under each idling pattern
   task automatic test_random_mix();
      int idle_pct [4] = '{0, 46, 0, 24};
      int stall_pct [4] = '{0, 0, 46, 24};
      cnt_type caps [4] = '{7'd64, 7'd9, 7'd100, 7'd64};
      int insert_pct;
      for (int ph = 0; ph < 4; ph++) begin
         write_capacity(caps[ph]);
         send_idle_pct = idle_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         for (int i = 0; i < 80; i++) begin
            insert_pct = ((i % 40) < 22) ? 72 : 28;
            if ($urandom_range(99) < insert_pct)
               send_op(MODE_INSERT, random_key());
            else
               send_op(MODE_REMOVE, key_type'($urandom));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_keys();
      test_capacity();
      test_fill_and_drain();
      test_random_mix();
      drain_queue();
      rsp_stall_pct = 0;
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hang guard
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_heap_ram.sv
rtl/binary_min_heap_queue_core.sv
tb/tb_binary_min_heap_queue_core.sv
